[hdl/sit_pkg.sv]
// Shared types and defaults for the sorted interval table.
// Used by the channel interfaces, the compare unit and the top level.
package sit_pkg;

   localparam int DEF_TABLE_DEPTH  = 16;
   localparam int DEF_ADDRESS_BITS = 48;
   localparam int DEF_TAG_BITS     = 32;

   typedef enum logic {
      ACT_LOOKUP = 1'b0,
      ACT_ADD    = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_REPLACED = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LK_RD,
      S_LK_CMP,
      S_MT_RD,
      S_MT_CMP,
      S_RM_RD,
      S_RM_WR,
      S_POS_INIT,
      S_POS_RD,
      S_POS_CMP,
      S_SH_RD,
      S_SH_WR,
      S_INS,
      S_RESP
   } state_type;

   typedef struct packed {
      logic covers;
      logic start_le;
      logic match;
   } cmp_type;

endpackage

[hdl/sit_ifs.sv]
// Request and response channel interfaces of the sorted interval table.
// Depends on sit_pkg for the action and status types.
interface sit_req_if import sit_pkg::*; #(
   parameter int ADDRESS_BITS = DEF_ADDRESS_BITS,
   parameter int TAG_BITS     = DEF_TAG_BITS
) ();
   logic                    valid;
   logic                    ready;
   action_type              action;
   logic [ADDRESS_BITS-1:0] address;
   logic [ADDRESS_BITS-1:0] span;
   logic [TAG_BITS-1:0]     tag;

   modport source (output valid, action, address, span, tag, input ready);
   modport sink (input valid, action, address, span, tag, output ready);
endinterface

interface sit_rsp_if import sit_pkg::*; #(
   parameter int ADDRESS_BITS = DEF_ADDRESS_BITS,
   parameter int TAG_BITS     = DEF_TAG_BITS
) ();
   logic                    valid;
   logic                    ready;
   logic                    hit;
   logic [ADDRESS_BITS-1:0] found_start;
   logic [ADDRESS_BITS-1:0] found_length;
   logic [TAG_BITS-1:0]     found_tag;
   status_type              status;

   modport source (output valid, hit, found_start, found_length, found_tag, status,
                   input ready);
   modport sink (input valid, hit, found_start, found_length, found_tag, status,
                 output ready);
endinterface

[hdl/sit_mem.sv]
// Entry storage of the sorted interval table: one write and one read port.
// Read data is registered; no dependencies.
module sit_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/sit_cmp.sv]
// Shared compare unit: tests one stored entry against the latched key.
// Depends on sit_pkg for the result struct.
module sit_cmp import sit_pkg::*; #(
   parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
   input  logic [ADDRESS_BITS-1:0] entry_start,
   input  logic [ADDRESS_BITS-1:0] entry_length,
   input  logic [ADDRESS_BITS-1:0] key_address,
   input  logic [ADDRESS_BITS-1:0] key_span,
   output cmp_type                 result
);

   logic [ADDRESS_BITS:0] diff;

   // The borrow bit tells whether the key lies below the entry start.
   assign diff = {1'b0, key_address} - {1'b0, entry_start};

   always_comb begin
      result.start_le = ~diff[ADDRESS_BITS];
      result.covers   = ~diff[ADDRESS_BITS] && (diff[ADDRESS_BITS-1:0] < entry_length);
      result.match    = (entry_start == key_address) && (entry_length == key_span);
   end

endmodule

[hdl/sorted_interval_table.sv]
// A table of up to TABLE_DEPTH address intervals kept sorted by start. A beat on the
// request channel either asks to add an interval or looks up an address, and each
// request gives exactly one response beat. One request is worked on at a time through
// an entry memory with one write port, one registered read port and one shared compare
// unit. A lookup reads and compares entries in turn until one covers the address, one
// starts above it or the last has been examined. An add may run the match scan, the shift
// that closes a replaced entry's gap, the position scan and the shift that opens the
// insertion slot, each of which handles an entry with a read state followed by a
// compare or write state. A new request is taken while a finished response still waits
// on the response channel; a request that finishes while the previous beat still waits
// holds until that beat is taken.
// Depends on sit_pkg, sit_ifs, sit_mem and sit_cmp.
module sorted_interval_table import sit_pkg::*; #(
   parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
   parameter int ADDRESS_BITS = DEF_ADDRESS_BITS,
   parameter int TAG_BITS     = DEF_TAG_BITS
) (
   input logic       clock,
   input logic       reset,
   sit_req_if.sink   req_if,
   sit_rsp_if.source rsp_if
);

   localparam int IDX_BITS  = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS  = $clog2(TABLE_DEPTH + 1);
   localparam int WORD_BITS = 2 * ADDRESS_BITS + TAG_BITS;

   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]     idx_ff, idx_in;
   logic [IDX_BITS-1:0]     pos_ff, pos_in;
   logic                    replaced_ff, replaced_in;
   action_type              act_ff, act_in;
   logic [ADDRESS_BITS-1:0] addr_ff, addr_in;
   logic [ADDRESS_BITS-1:0] span_ff, span_in;
   logic [TAG_BITS-1:0]     tag_ff, tag_in;
   logic                    res_hit_ff, res_hit_in;
   logic [ADDRESS_BITS-1:0] res_start_ff, res_start_in;
   logic [ADDRESS_BITS-1:0] res_len_ff, res_len_in;
   logic [TAG_BITS-1:0]     res_tag_ff, res_tag_in;
   status_type              res_status_ff, res_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic [ADDRESS_BITS-1:0] rsp_start_ff, rsp_start_in;
   logic [ADDRESS_BITS-1:0] rsp_len_ff, rsp_len_in;
   logic [TAG_BITS-1:0]     rsp_tag_ff, rsp_tag_in;
   status_type              rsp_status_ff, rsp_status_in;

   logic                    req_accept;
   logic                    rsp_free;
   logic [CNT_BITS-1:0]     idx_inc;
   logic                    last;
   logic                    full;

   logic                    mem_we;
   logic [IDX_BITS-1:0]     mem_waddr;
   logic [WORD_BITS-1:0]    mem_wdata;
   logic [IDX_BITS-1:0]     mem_raddr;
   logic [WORD_BITS-1:0]    mem_rdata;
   logic [ADDRESS_BITS-1:0] ent_start;
   logic [ADDRESS_BITS-1:0] ent_len;
   logic [TAG_BITS-1:0]     ent_tag;
   cmp_type                 cmp;

   sit_mem #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (WORD_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign ent_start = mem_rdata[WORD_BITS-1 -: ADDRESS_BITS];
   assign ent_len   = mem_rdata[ADDRESS_BITS+TAG_BITS-1 -: ADDRESS_BITS];
   assign ent_tag   = mem_rdata[TAG_BITS-1:0];

   sit_cmp #(
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_cmp (
      .entry_start  (ent_start),
      .entry_length (ent_len),
      .key_address  (addr_ff),
      .key_span     (span_ff),
      .result       (cmp)
   );

   assign req_accept = req_if.valid && req_if.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_if.ready;
   assign idx_inc    = idx_ff + CNT_BITS'(1);
   assign last       = (idx_inc == cnt_ff);
   assign full       = (cnt_ff == CNT_BITS'(TABLE_DEPTH));

   assign req_if.ready        = (state_ff == S_IDLE);
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.hit          = rsp_hit_ff;
   assign rsp_if.found_start  = rsp_start_ff;
   assign rsp_if.found_length = rsp_len_ff;
   assign rsp_if.found_tag    = rsp_tag_ff;
   assign rsp_if.status       = rsp_status_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_if.action == ACT_ADD) begin
                  if (req_if.span == '0) begin
                     state_in = S_RESP;
                  end else if (cnt_ff == '0) begin
                     state_in = S_INS;
                  end else begin
                     state_in = S_MT_RD;
                  end
               end else if (cnt_ff == '0) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_LK_RD;
               end
            end
         end
         S_LK_RD: state_in = S_LK_CMP;
         S_LK_CMP: begin
            if (cmp.covers || !cmp.start_le || last) begin
               state_in = S_RESP;
            end else begin
               state_in = S_LK_RD;
            end
         end
         S_MT_RD: state_in = S_MT_CMP;
         S_MT_CMP: begin
            if (cmp.match) begin
               state_in = last ? S_POS_INIT : S_RM_RD;
            end else if (last) begin
               state_in = full ? S_RESP : S_POS_INIT;
            end else begin
               state_in = S_MT_RD;
            end
         end
         S_RM_RD: state_in = S_RM_WR;
         S_RM_WR: state_in = last ? S_POS_INIT : S_RM_RD;
         S_POS_INIT: state_in = (cnt_ff == '0) ? S_INS : S_POS_RD;
         S_POS_RD: state_in = S_POS_CMP;
         S_POS_CMP: begin
            if (cmp.start_le) begin
               state_in = last ? S_INS : S_POS_RD;
            end else begin
               state_in = S_SH_RD;
            end
         end
         S_SH_RD: state_in = S_SH_WR;
         S_SH_WR: state_in = (idx_ff[IDX_BITS-1:0] == pos_ff) ? S_INS : S_SH_RD;
         S_INS: state_in = S_RESP;
         S_RESP: state_in = rsp_free ? S_IDLE : S_RESP;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath, memory control and result registers.
   always_comb begin
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      replaced_in   = replaced_ff;
      act_in        = act_ff;
      addr_in       = addr_ff;
      span_in       = span_ff;
      tag_in        = tag_ff;
      res_hit_in    = res_hit_ff;
      res_start_in  = res_start_ff;
      res_len_in    = res_len_ff;
      res_tag_in    = res_tag_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff[IDX_BITS-1:0];
      mem_wdata     = mem_rdata;
      mem_raddr     = idx_ff[IDX_BITS-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               act_in        = req_if.action;
               addr_in       = req_if.address;
               span_in       = req_if.span;
               tag_in        = req_if.tag;
               replaced_in   = 1'b0;
               idx_in        = '0;
               res_hit_in    = 1'b0;
               res_start_in  = '0;
               res_len_in    = '0;
               res_tag_in    = '0;
               res_status_in = ((req_if.action == ACT_ADD) && (req_if.span == '0)) ?
                               ST_EMPTY : ST_DONE;
            end
         end
         S_LK_CMP: begin
            if (cmp.covers) begin
               res_hit_in   = 1'b1;
               res_start_in = ent_start;
               res_len_in   = ent_len;
               res_tag_in   = ent_tag;
            end else if (cmp.start_le && !last) begin
               idx_in = idx_inc;
            end
         end
         S_MT_CMP: begin
            if (cmp.match) begin
               replaced_in = 1'b1;
               if (last) begin
                  cnt_in = cnt_ff - CNT_BITS'(1);
               end else begin
                  idx_in = idx_inc;
               end
            end else if (last) begin
               if (full) begin
                  res_status_in = ST_FULL;
               end
            end else begin
               idx_in = idx_inc;
            end
         end
         S_RM_WR: begin
            // Close the gap left by the replaced entry.
            mem_we    = 1'b1;
            mem_waddr = IDX_BITS'(idx_ff - CNT_BITS'(1));
            if (last) begin
               cnt_in = cnt_ff - CNT_BITS'(1);
            end else begin
               idx_in = idx_inc;
            end
         end
         S_POS_INIT: idx_in = '0;
         S_POS_CMP: begin
            if (cmp.start_le) begin
               idx_in = idx_inc;
            end else begin
               pos_in = idx_ff[IDX_BITS-1:0];
               idx_in = cnt_ff - CNT_BITS'(1);
            end
         end
         S_SH_WR: begin
            // Open the insertion slot, moving from the tail downward.
            mem_we    = 1'b1;
            mem_waddr = idx_inc[IDX_BITS-1:0];
            if (idx_ff[IDX_BITS-1:0] != pos_ff) begin
               idx_in = idx_ff - CNT_BITS'(1);
            end
         end
         S_INS: begin
            mem_we        = 1'b1;
            mem_wdata     = {addr_ff, span_ff, tag_ff};
            cnt_in        = cnt_ff + CNT_BITS'(1);
            res_status_in = replaced_ff ? ST_REPLACED : ST_DONE;
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = res_hit_ff;
               rsp_start_in  = res_start_ff;
               rsp_len_in    = res_len_ff;
               rsp_tag_in    = res_tag_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      replaced_ff   <= replaced_in;
      act_ff        <= act_in;
      addr_ff       <= addr_in;
      span_ff       <= span_in;
      tag_ff        <= tag_in;
      res_hit_ff    <= res_hit_in;
      res_start_ff  <= res_start_in;
      res_len_ff    <= res_len_in;
      res_tag_ff    <= res_tag_in;
      res_status_ff <= res_status_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_status_ff <= rsp_status_in;
   end

   // The entry count never exceeds the table depth.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(TABLE_DEPTH))
      else $error("entry count exceeds table depth");

   // The table is written only while an add is in progress.
   a_write_on_add: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (act_ff == ACT_ADD))
      else $error("table written during a lookup");

   // No write lands beyond the slot just past the last valid entry.
   a_write_addr: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (CNT_BITS'(mem_waddr) <= cnt_ff))
      else $error("table write beyond the valid entries");

   // The count moves by at most one entry per cycle.
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((cnt_ff == $past(cnt_ff)) ||
                         (cnt_ff == $past(cnt_ff) + CNT_BITS'(1)) ||
                         (cnt_ff == $past(cnt_ff) - CNT_BITS'(1))))
      else $error("entry count jumped");

   // A response beat that reports a hit carries the done status, as a lookup gives.
   a_hit_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_hit_ff) |-> (rsp_status_ff == ST_DONE))
      else $error("hit reported with an add status");

endmodule
